// ===== rtl/apvsc_pkg.sv =====
// Shared types and constants of the accelerometer peak/valley step counter.
// No dependencies; every other file of the block refers to it by scoped names.
package apvsc_pkg;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int AXIS_W     = 16;
  localparam int MAG_W      = 16;
  localparam int COUNT_W    = 16;
  localparam int SUM_W      = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Magnitude window
  localparam int WIN_LEN = 7;
  localparam int FILL_W  = $clog2(WIN_LEN + 1);
  localparam int CENTER  = WIN_LEN / 2;

  // Square root: one result bit per iteration
  localparam int SQRT_STEPS = MAG_W;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

  // Largest magnitude a 16 bit vector can produce
  localparam logic [MAG_W-1:0] MAG_MAX = 16'd56755;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 1'd1;

  // Configuration reset values
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd4014;
  localparam logic [CFG_DATA_W-1:0] INTERVAL_RESET  = 16'd200;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] peak_threshold;
    logic [CFG_DATA_W-1:0] min_peak_interval;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] step_total;
    logic               step_seen;
  } det_res_t;

endpackage

// ===== rtl/apvsc_if.sv =====
// Valid/ready channel interfaces for the sample input and the step result.
// Depends on apvsc_pkg for field widths.
interface apvsc_in_if;
  logic                           valid;
  logic                           ready;
  logic [apvsc_pkg::TIME_W-1:0]   sample_time;
  logic signed [apvsc_pkg::AXIS_W-1:0] accel_x;
  logic signed [apvsc_pkg::AXIS_W-1:0] accel_y;
  logic signed [apvsc_pkg::AXIS_W-1:0] accel_z;

  modport source (output valid, sample_time, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, sample_time, accel_x, accel_y, accel_z, output ready);
endinterface

interface apvsc_out_if;
  logic                            valid;
  logic                            ready;
  logic [apvsc_pkg::COUNT_W-1:0]   step_total;
  logic                            step_seen;
  logic [apvsc_pkg::MAG_W-1:0]     magnitude;

  modport source (output valid, step_total, step_seen, magnitude, input ready);
  modport sink   (input valid, step_total, step_seen, magnitude, output ready);
endinterface

// ===== rtl/apvsc_sumsq.sv =====
// Sum of squares of the three axes through one shared 16x16 multiplier.
// Axes pass through a three-entry operand line, one per cycle. Uses apvsc_pkg.
module apvsc_sumsq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [apvsc_pkg::AXIS_W-1:0] accel_x,
  input  logic signed [apvsc_pkg::AXIS_W-1:0] accel_y,
  input  logic signed [apvsc_pkg::AXIS_W-1:0] accel_z,
  output logic                                done,
  output logic [apvsc_pkg::SUM_W-1:0]         sum
);

  localparam int AW = apvsc_pkg::AXIS_W;
  localparam int SW = apvsc_pkg::SUM_W;

  function automatic logic [AW-1:0] abs_axis(input logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  logic [AW-1:0] ax_r [0:2];
  logic [SW-1:0] prod_r;
  logic [SW-1:0] acc_r;
  logic [1:0]    step_r;
  logic          busy_r;
  logic          last;

  assign last = busy_r && (step_r == 2'd3);
  assign done = last;
  assign sum  = acc_r + prod_r;

  // Control: three products and the final add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= 2'd0;
    end else if (busy_r) begin
      step_r <= step_r + 2'd1;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operand line, product register and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      ax_r[0] <= abs_axis(accel_x);
      ax_r[1] <= abs_axis(accel_y);
      ax_r[2] <= abs_axis(accel_z);
      acc_r   <= '0;
    end else if (busy_r) begin
      ax_r[0] <= ax_r[1];
      ax_r[1] <= ax_r[2];
      prod_r  <= {{(SW-AW){1'b0}}, ax_r[0]} * {{(SW-AW){1'b0}}, ax_r[0]};
      if (step_r != 2'd0) begin
        acc_r <= acc_r + prod_r;
      end
    end
  end

endmodule

// ===== rtl/apvsc_sqrt.sv =====
// Digit-serial integer square root: two radicand bits in, one root bit out
// per cycle, restoring form. Uses apvsc_pkg.
module apvsc_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [apvsc_pkg::SUM_W-1:0]   radicand,
  output logic                          done,
  output logic [apvsc_pkg::MAG_W-1:0]   root
);

  localparam int SW = apvsc_pkg::SUM_W;
  localparam int MW = apvsc_pkg::MAG_W;
  localparam int RW = MW + 1;
  localparam int TW = MW + 3;
  localparam int CW = apvsc_pkg::SQRT_CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(apvsc_pkg::SQRT_STEPS - 1);

  logic [SW-1:0] rad_r;
  logic [RW-1:0] rem_r;
  logic [MW-1:0] root_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [TW-1:0] rem_t;
  logic [TW-1:0] trial;
  logic          fits;
  logic [RW-1:0] rem_nxt;

  assign done = done_r;
  assign root = root_r;

  // One root digit: bring down two bits, try subtracting 4*root+1
  always_comb begin
    rem_t   = {rem_r, rad_r[SW-1:SW-2]};
    trial   = {1'b0, root_r, 2'b01};
    fits    = rem_t >= trial;
    rem_nxt = fits ? RW'(rem_t - trial) : RW'(rem_t);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[MW-2:0], fits};
    end
  end

  // A new root is never started on top of one in flight
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("sqrt restarted while busy");

endmodule

// ===== rtl/apvsc_detect.sv =====
// Magnitude window, peak/valley test and step bookkeeping.
// Uses apvsc_pkg for the window length, config and result structs.
module apvsc_detect (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              upd,
  input  logic [apvsc_pkg::MAG_W-1:0]       mag,
  input  logic [apvsc_pkg::TIME_W-1:0]      sample_time,
  input  apvsc_pkg::cfg_t                   cfg,
  output apvsc_pkg::det_res_t               res
);

  localparam int MW = apvsc_pkg::MAG_W;
  localparam int TW = apvsc_pkg::TIME_W;
  localparam int CW = apvsc_pkg::COUNT_W;
  localparam int FW = apvsc_pkg::FILL_W;
  localparam int WL = apvsc_pkg::WIN_LEN;
  localparam int CT = apvsc_pkg::CENTER;
  localparam logic [FW-1:0] FILL_FULL = FW'(WL);

  logic [MW-1:0] win_r [0:WL-1];
  logic [FW-1:0] fill_r;
  logic [MW-1:0] valley_r;
  logic [TW-1:0] peak_time_r;
  logic [CW-1:0] count_r;

  logic [MW-1:0] nw [0:WL-1];
  logic          full;
  logic          is_peak;
  logic          is_valley;
  logic          amp_ok;
  logic          gap_ok;
  logic          step;

  // Window as it stands after this sample is appended
  always_comb begin
    for (int i = 0; i < WL - 1; i++) begin
      nw[i] = win_r[i+1];
    end
    nw[WL-1] = mag;
  end

  // Strict monotone shape around the center entry
  always_comb begin
    is_peak   = 1'b1;
    is_valley = 1'b1;
    for (int i = 0; i < CT; i++) begin
      is_peak   = is_peak   && (nw[i+1] > nw[i]);
      is_valley = is_valley && (nw[i+1] < nw[i]);
    end
    for (int i = CT; i < WL - 1; i++) begin
      is_peak   = is_peak   && (nw[i] > nw[i+1]);
      is_valley = is_valley && (nw[i] < nw[i+1]);
    end
  end

  // Peak minus valley above threshold, and enough time since last step
  assign full   = fill_r == FILL_FULL;
  assign amp_ok = {1'b0, nw[CT]} > ({1'b0, valley_r} + {1'b0, cfg.peak_threshold});
  assign gap_ok = (sample_time - peak_time_r) > TW'(cfg.min_peak_interval);
  assign step   = upd && full && is_peak && amp_ok && gap_ok;

  assign res.step_seen  = step;
  assign res.step_total = count_r + CW'(step);

  // Window shift line
  always_ff @(posedge clk) begin
    if (upd) begin
      for (int i = 0; i < WL; i++) begin
        win_r[i] <= nw[i];
      end
    end
  end

  // Fill level, valley, last peak time and step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      valley_r    <= '0;
      peak_time_r <= '0;
      count_r     <= '0;
    end else if (upd) begin
      if (!full) begin
        fill_r <= fill_r + FW'(1);
      end else if (is_valley) begin
        valley_r <= nw[CT];
      end
      if (step) begin
        count_r     <= count_r + CW'(1);
        peak_time_r <= sample_time;
      end
    end
  end

  // A counted step advances the counter by exactly one
  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> count_r == $past(count_r) + CW'(1))
    else $error("step counter did not advance on a counted step");

  // No step before the window is full
  a_no_early_step: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && fill_r != FILL_FULL) |-> !res.step_seen)
    else $error("step counted while window filling");

endmodule

// ===== rtl/accel_peak_valley_step_counter_top.sv =====
// Top level of the accelerometer peak/valley step counter: sequencer, config
// registers and output register. Uses apvsc_pkg, apvsc_if, apvsc_sumsq,
// apvsc_sqrt and apvsc_detect.
//
//   channel  | direction | handshake        | beat contents
//   ---------+-----------+------------------+------------------------------------
//   in_bus   | in        | valid/ready      | sample_time, accel_x, accel_y, accel_z
//   out_bus  | out       | valid/ready      | step_total, step_seen, magnitude
//   cfg_*    | in        | cfg_we, no ready | cfg_index, cfg_data
//
// One sample at a time: the sum of squares in the shared squaring multiplier,
// then the bit-serial square root and its registered hand-over, then the
// update, then ready again.
// A result waits in the output register; a new sample is taken meanwhile, and
// its update cycle stalls until the waiting beat is taken.
// Synchronous active-low reset returns config registers to their defaults and
// clears the counters, the fill level and the valley.
module accel_peak_valley_step_counter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  apvsc_in_if.sink                            in_bus,
  apvsc_out_if.source                         out_bus,
  input  logic                                cfg_we,
  input  logic [apvsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [apvsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SUMSQ  = 2'd1;
  localparam logic [1:0] S_ROOT   = 2'd2;
  localparam logic [1:0] S_UPDATE = 2'd3;

  logic [1:0]                        state_r;
  logic [1:0]                        state_nxt;
  apvsc_pkg::cfg_t                   cfg_r;
  logic [apvsc_pkg::TIME_W-1:0]      time_r;
  logic [apvsc_pkg::MAG_W-1:0]       mag_r;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [apvsc_pkg::COUNT_W-1:0]     out_total_r;
  logic                              out_seen_r;
  logic [apvsc_pkg::MAG_W-1:0]       out_mag_r;

  logic                              accept;
  logic                              upd;
  logic                              sumsq_done;
  logic [apvsc_pkg::SUM_W-1:0]       sumsq_sum;
  logic                              sqrt_done;
  logic [apvsc_pkg::MAG_W-1:0]       sqrt_root;
  apvsc_pkg::det_res_t               det_res;

  assign in_bus.ready       = state_r == S_IDLE;
  assign accept             = in_bus.valid && in_bus.ready;
  assign upd                = (state_r == S_UPDATE) && (!out_valid_r || out_bus.ready);

  assign out_bus.valid      = out_valid_r;
  assign out_bus.step_total = out_total_r;
  assign out_bus.step_seen  = out_seen_r;
  assign out_bus.magnitude  = out_mag_r;

  // Squares of the three axes
  apvsc_sumsq u_sumsq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .accel_x (in_bus.accel_x),
    .accel_y (in_bus.accel_y),
    .accel_z (in_bus.accel_z),
    .done    (sumsq_done),
    .sum     (sumsq_sum)
  );

  // Floor square root of the sum
  apvsc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sumsq_done),
    .radicand (sumsq_sum),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Window and step decision
  apvsc_detect u_detect (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (upd),
    .mag         (mag_r),
    .sample_time (time_r),
    .cfg         (cfg_r),
    .res         (det_res)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SUMSQ;
      end
      S_SUMSQ: begin
        if (sumsq_done) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (sqrt_done) state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (upd) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: drop when taken, raise on update
  assign out_valid_nxt = (out_valid_r && !out_bus.ready) || upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.peak_threshold    <= apvsc_pkg::THRESHOLD_RESET;
      cfg_r.min_peak_interval <= apvsc_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        apvsc_pkg::CFG_PEAK_THRESHOLD: cfg_r.peak_threshold    <= cfg_data;
        apvsc_pkg::CFG_MIN_INTERVAL:   cfg_r.min_peak_interval <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold the timestamp and magnitude of the sample in flight; load the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      time_r <= in_bus.sample_time;
    end
    if (sqrt_done) begin
      mag_r <= sqrt_root;
    end
    if (upd) begin
      out_total_r <= det_res.step_total;
      out_seen_r  <= det_res.step_seen;
      out_mag_r   <= mag_r;
    end
  end

  // A sum only completes while the sequencer waits for it
  a_sumsq_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    sumsq_done |-> state_r == S_SUMSQ)
    else $error("sum of squares completed outside its state");

  // A result beat appears only from the update cycle
  a_beat_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPDATE))
    else $error("result raised without an update");

  // Magnitudes stay within what three 16 bit axes can give
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_mag_r <= apvsc_pkg::MAG_MAX)
    else $error("magnitude out of range");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the accelerometer peak/valley step counter: directed and random samples.
// Depends on apvsc_pkg, apvsc_if and accel_peak_valley_step_counter_top.
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT = 17;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [apvsc_pkg::TIME_W-1:0]        stamp;
    logic signed [apvsc_pkg::AXIS_W-1:0] ax;
    logic signed [apvsc_pkg::AXIS_W-1:0] ay;
    logic signed [apvsc_pkg::AXIS_W-1:0] az;
  } sample_t;

  typedef struct packed {
    logic [apvsc_pkg::COUNT_W-1:0] total;
    logic                          seen;
    logic [apvsc_pkg::MAG_W-1:0]   mag;
  } step_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [apvsc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [apvsc_pkg::CFG_DATA_W-1:0] cfg_data;

  apvsc_in_if in_bus ();
  apvsc_out_if out_bus ();

  accel_peak_valley_step_counter_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Stimulus and expectations
  sample_t      samples_to_send[$];
  step_report_t reports_due[$];
  logic         sample_taken;
  bit           steady_flow = 1'b0;
  logic [apvsc_pkg::TIME_W-1:0] clock_ms;
  int           mismatch_count = 0;
  int           results_seen = 0;
  int unsigned  cycle_count = 0;
  int           holdoff_left = 0;
  int           next_holdoff_at = 400;

  // Step tracker state
  logic [apvsc_pkg::MAG_W-1:0]      mag_window [apvsc_pkg::WIN_LEN];
  int                               window_fill;
  logic [apvsc_pkg::MAG_W-1:0]      valley_level;
  logic [apvsc_pkg::TIME_W-1:0]     last_step_stamp;
  logic [apvsc_pkg::COUNT_W-1:0]    step_count;
  logic [apvsc_pkg::CFG_DATA_W-1:0] threshold_reg;
  logic [apvsc_pkg::CFG_DATA_W-1:0] interval_reg;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [apvsc_pkg::MAG_W-1:0] floor_root(input logic [31:0] n);
    logic [apvsc_pkg::MAG_W-1:0] r;
    logic [31:0] cand;
    r = '0;
    // Settle one result bit per pass, top down
    for (int b = apvsc_pkg::MAG_W - 1; b >= 0; b--) begin
      cand = {16'd0, r | (16'd1 << b)};
      if (cand * cand <= n) r = r | (16'd1 << b);
    end
    return r;
  endfunction

  // Advance the tracker by one sample and return the beat it must produce
  function automatic step_report_t track_sample(input sample_t s);
    longint sq;
    logic [apvsc_pkg::MAG_W-1:0] mag;
    logic [apvsc_pkg::TIME_W-1:0] dt;
    bit is_peak;
    bit is_valley;
    int gap;
    int peak_i;
    int valley_i;
    int thr_i;
    step_report_t r;
    sq = longint'(s.ax) * s.ax + longint'(s.ay) * s.ay + longint'(s.az) * s.az;
    mag = floor_root(32'(sq));
    r.seen = 1'b0;
    if (window_fill < apvsc_pkg::WIN_LEN) begin
      mag_window[window_fill] = mag;
      window_fill++;
    end else begin
      // Drop the oldest, append the newest
      for (int i = 0; i < apvsc_pkg::WIN_LEN - 1; i++) mag_window[i] = mag_window[i + 1];
      mag_window[apvsc_pkg::WIN_LEN - 1] = mag;
      is_peak = 1'b1;
      is_valley = 1'b1;
      for (int i = 0; i < apvsc_pkg::CENTER; i++) begin
        if (!(mag_window[i + 1] > mag_window[i])) is_peak = 1'b0;
        if (!(mag_window[i + 1] < mag_window[i])) is_valley = 1'b0;
      end
      for (int i = apvsc_pkg::CENTER; i < apvsc_pkg::WIN_LEN - 1; i++) begin
        if (!(mag_window[i] > mag_window[i + 1])) is_peak = 1'b0;
        if (!(mag_window[i] < mag_window[i + 1])) is_valley = 1'b0;
      end
      if (is_peak) begin
        // Signed gap: a valley above the peak never qualifies
        peak_i = int'(mag_window[apvsc_pkg::CENTER]);
        valley_i = int'(valley_level);
        thr_i = int'(threshold_reg);
        gap = peak_i - valley_i;
        dt = s.stamp - last_step_stamp;
        if (gap > thr_i && dt > {16'd0, interval_reg}) begin
          step_count = step_count + 1'b1;
          last_step_stamp = s.stamp;
          r.seen = 1'b1;
        end
      end else if (is_valley) begin
        valley_level = mag_window[apvsc_pkg::CENTER];
      end
    end
    r.total = step_count;
    r.mag = mag;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("ERROR beat %0d %s: got %0d expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Monitor: record accepted samples, check accepted results, watch the clock
  always @(posedge clk) begin
    step_report_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else if (!rst_n) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready)
        reports_due.push_back(track_sample({in_bus.sample_time, in_bus.accel_x,
                                            in_bus.accel_y, in_bus.accel_z}));
      if (out_bus.valid && out_bus.ready) begin
        results_seen <= results_seen + 1;
        if (reports_due.size() == 0) begin
          flag_mismatch("beat with nothing outstanding, magnitude", out_bus.magnitude, -1);
        end else begin
          want = reports_due.pop_front();
          if (out_bus.step_total !== want.total)
            flag_mismatch("step_total", out_bus.step_total, want.total);
          if (out_bus.step_seen !== want.seen)
            flag_mismatch("step_seen", out_bus.step_seen, want.seen);
          if (out_bus.magnitude !== want.mag)
            flag_mismatch("magnitude", out_bus.magnitude, want.mag);
        end
      end
    end
  end

  // Driver: hold a beat until taken, otherwise offer the next sample or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (sample_taken) void'(samples_to_send.pop_front());
      if (in_bus.valid && !sample_taken) begin
        in_bus.valid <= 1'b1;
      end else if (samples_to_send.size() != 0 &&
                   (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
        in_bus.valid <= 1'b1;
        in_bus.sample_time <= samples_to_send[0].stamp;
        in_bus.accel_x <= samples_to_send[0].ax;
        in_bus.accel_y <= samples_to_send[0].ay;
        in_bus.accel_z <= samples_to_send[0].az;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus a long hold-off every few hundred beats
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      out_bus.ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (results_seen >= next_holdoff_at) begin
      out_bus.ready <= 1'b0;
      holdoff_left <= 200;
      next_holdoff_at <= next_holdoff_at + 700;
    end else begin
      out_bus.ready <= steady_flow || $urandom_range(99) >= IDLE_PCT;
    end
  end

  task automatic add_sample(input logic [apvsc_pkg::TIME_W-1:0] t,
                            input int x, input int y, input int z);
    sample_t s;
    s.stamp = t;
    s.ax = 16'(x);
    s.ay = 16'(y);
    s.az = 16'(z);
    samples_to_send.push_back(s);
  endtask

  // Spread scale k over one, two or three axes with random signs
  task automatic add_scaled(input int k, input int axes, input int delta);
    int v[3];
    int lead;
    lead = $urandom_range(2);
    for (int i = 0; i < 3; i++) v[i] = 0;
    for (int i = 0; i < axes; i++) v[(lead + i) % 3] = $urandom_range(1) ? -k : k;
    clock_ms = clock_ms + delta;
    add_sample(clock_ms, v[0], v[1], v[2]);
  endtask

  // Mostly rise/fall waves with random content, some raw noise
  task automatic add_waves(input int count);
    int made;
    int k;
    int axes;
    int stride;
    int up;
    int down;
    int step;
    made = 0;
    k = $urandom_range(32767);
    while (made < count) begin
      if ($urandom_range(99) < 20) begin
        if ($urandom_range(9) == 0) clock_ms = clock_ms + $urandom;
        else clock_ms = clock_ms + $urandom_range(1, 120);
        add_sample(clock_ms, $urandom, $urandom, $urandom);
        made++;
      end else begin
        axes = $urandom_range(1, 3);
        case ($urandom_range(2))
          0: stride = 3;
          1: stride = 300;
          default: stride = 4000;
        endcase
        up = $urandom_range(3, 6);
        down = $urandom_range(3, 6);
        if ($urandom_range(9) < 3) k = $urandom_range(32767);
        if (k > 32767 - up * stride) k = 32767 - up * stride;
        for (int i = 0; i < up + down && made < count; i++) begin
          step = $urandom_range(1, stride);
          k = (i < up) ? k + step : k - step;
          if (k < 0) k = 0;
          if (k > 32767) k = 32767;
          add_scaled(k, axes, $urandom_range(1, 120));
          made++;
        end
      end
    end
  endtask

  task automatic wait_for_drain();
    while (samples_to_send.size() != 0 || reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [apvsc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [apvsc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == apvsc_pkg::CFG_PEAK_THRESHOLD) threshold_reg = val;
    else if (idx == apvsc_pkg::CFG_MIN_INTERVAL) interval_reg = val;
  endtask

  task automatic run_phase(input logic [apvsc_pkg::CFG_DATA_W-1:0] thr,
                           input logic [apvsc_pkg::CFG_DATA_W-1:0] ivl,
                           input int count, input bit calm);
    wait_for_drain();
    set_register(apvsc_pkg::CFG_PEAK_THRESHOLD, thr);
    set_register(apvsc_pkg::CFG_MIN_INTERVAL, ivl);
    @(posedge clk);
    steady_flow = calm;
    add_waves(count);
  endtask

  initial begin
    int scale_seq[19];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 1'b0;
    in_bus.sample_time = '0;
    in_bus.accel_x = '0;
    in_bus.accel_y = '0;
    in_bus.accel_z = '0;
    out_bus.ready = 1'b0;
    threshold_reg = apvsc_pkg::THRESHOLD_RESET;
    interval_reg = apvsc_pkg::INTERVAL_RESET;
    window_fill = 0;
    valley_level = '0;
    last_step_stamp = '0;
    step_count = '0;
    for (int i = 0; i < apvsc_pkg::WIN_LEN; i++) mag_window[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the window with axis and timestamp extremes
    add_sample(32'h0000_0000, -32768, -32768, -32768);
    add_sample(32'hFFFF_FFFF, 32767, 32767, 32767);
    add_sample(32'h0000_0000, 0, 0, 0);
    add_sample(32'h5555_5555, -1, -1, -1);
    add_sample(32'hAAAA_AAAA, 1, -32768, 0);
    add_sample(32'h8000_0000, 32767, -32768, 1);
    add_sample(32'h7FFF_FFFF, -32768, 0, 32767);
    // Valley, a counted peak across the time wrap, a lower valley, a counted lower peak
    scale_seq = '{30000, 29000, 28000, 27000, 28000, 29000, 30000,
                  31000, 32767, 31000, 30000, 29000,
                  500, 1000, 2000, 3000, 2000, 1000, 500};
    clock_ms = 32'hFFFF_FE2C;
    for (int i = 0; i < 19; i++) add_scaled(scale_seq[i], (i >= 12) ? 3 : 1, 64);

    // Random phases over several register settings
    clock_ms = $urandom;
    run_phase(16'd0, 16'd0, 300, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 150, 1'b0);
    run_phase(16'($urandom_range(12000)), 16'($urandom_range(600)), 300, 1'b1);
    clock_ms = 32'hFFFF_F000;
    run_phase(16'd1000, 16'd100, 300, 1'b0);
    run_phase(16'($urandom_range(20000)), 16'($urandom_range(400)), 350, 1'b0);
    run_phase(16'd0, 16'hFFFF, 200, 1'b0);

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
